[rtl/core/text_console_cell_writer_unit_assert.svh]
// ----------------------------------------------------------------------------
// Text console cell writer assertion macros
// Short forms for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console cell writer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console cell writer: next-cycle check failed");

`endif

[rtl/core/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared constants, command codes and the result record.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths of the stream items.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Control characters.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              scrolled;
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
  } result_t;

endpackage

[rtl/core/tccw_cell_ram.sv]
// ----------------------------------------------------------------------------
// Character cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_ram #(
  parameter int DEPTH = tccw_pkg::ROWS_DEF * tccw_pkg::COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [tccw_pkg::CHAR_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [tccw_pkg::CHAR_W-1:0] rdata_o
);

  logic [tccw_pkg::CHAR_W-1:0] mem [DEPTH];
  logic [tccw_pkg::CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tccw_seq.sv]
// ----------------------------------------------------------------------------
// Text console sequencer
// Cursor, scroll offset and the per-command sequence over the cell memory.
// ----------------------------------------------------------------------------
module tccw_seq #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF,
  parameter int AW      = $clog2(ROWS * COLUMNS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tccw_pkg::CMD_W-1:0]  cmd_i,
  input  logic [tccw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tccw_pkg::RROW_W-1:0] read_row_i,
  input  logic [tccw_pkg::RCOL_W-1:0] read_col_i,
  output logic                        res_valid_o,
  output tccw_pkg::result_t           res_o,
  input  logic                        res_ready_i,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [tccw_pkg::CHAR_W-1:0] ram_wdata_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic [tccw_pkg::CHAR_W-1:0] ram_rdata_i
);

  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(ROWS);
  localparam int Depth = ROWS * COLUMNS;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [ColW-1:0]             col_q, col_d;
  logic [RowW-1:0]             row_q, row_d;
  logic [RowW-1:0]             top_q, top_d;
  logic [AW-1:0]               sweep_addr_q, sweep_addr_d;
  logic [AW-1:0]               sweep_last_q, sweep_last_d;
  logic                        scrolled_q, scrolled_d;
  logic [tccw_pkg::CHAR_W-1:0] cell_q, cell_d;

  logic                        accept;
  logic                        read_in_range;
  logic [RowW-1:0]             cur_prow;
  logic [RowW-1:0]             top_next;

  // Logical rows are stored rotated by the scroll offset.
  function automatic logic [RowW-1:0] phys_row(logic [RowW-1:0] r, logic [RowW-1:0] top);
    logic [RowW:0] sum;
    sum = {1'b0, r} + {1'b0, top};
    if (sum >= (RowW+1)'(ROWS)) begin
      sum = sum - (RowW+1)'(ROWS);
    end
    return sum[RowW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [RowW-1:0] prow, logic [ColW-1:0] col);
    return AW'(32'(prow) * COLUMNS + 32'(col));
  endfunction

  assign in_ready_o    = (state_q == ST_IDLE);
  assign accept        = in_valid_i && in_ready_o;
  assign read_in_range = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLUMNS);
  assign cur_prow      = phys_row(row_q, top_q);
  assign top_next      = (top_q == RowW'(ROWS - 1)) ? '0 : top_q + 1'b1;

  assign ram_raddr_o = cell_addr(phys_row(RowW'(read_row_i), top_q), ColW'(read_col_i));

  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.cursor_col  = tccw_pkg::OCOL_W'(col_q);
  assign res_o.cursor_row  = tccw_pkg::OROW_W'(row_q);
  assign res_o.scrolled    = scrolled_q;
  assign res_o.cell_char   = cell_q;

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    top_d        = top_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    scrolled_d   = scrolled_q;
    cell_d       = cell_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = sweep_addr_q;
    ram_wdata_o  = '0;

    case (state_q)
      ST_INIT, ST_SWEEP: begin
        ram_we_o = 1'b1;
        if (sweep_addr_q == sweep_last_q) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          sweep_addr_d = sweep_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scrolled_d = 1'b0;
          cell_d     = '0;
          state_d    = ST_DONE;
          case (cmd_i)
            tccw_pkg::CMD_PUT: begin
              if (char_code_i == tccw_pkg::CHAR_BACKSPACE) begin
                if (col_q != '0) begin
                  col_d       = col_q - 1'b1;
                  ram_we_o    = 1'b1;
                  ram_waddr_o = cell_addr(cur_prow, col_q - 1'b1);
                end
              end else begin
                if (char_code_i != tccw_pkg::CHAR_NEWLINE) begin
                  ram_we_o    = 1'b1;
                  ram_waddr_o = cell_addr(cur_prow, col_q);
                  ram_wdata_o = char_code_i;
                end
                if (char_code_i == tccw_pkg::CHAR_NEWLINE ||
                    col_q == ColW'(COLUMNS - 1)) begin
                  col_d = '0;
                  if (row_q != RowW'(ROWS - 1)) begin
                    row_d = row_q + 1'b1;
                  end else begin
                    // The old top row becomes the blank bottom row.
                    scrolled_d   = 1'b1;
                    top_d        = top_next;
                    sweep_addr_d = cell_addr(top_q, '0);
                    sweep_last_d = cell_addr(top_q, ColW'(COLUMNS - 1));
                    state_d      = ST_SWEEP;
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            end
            tccw_pkg::CMD_CLEAR: begin
              col_d        = '0;
              row_d        = '0;
              top_d        = '0;
              sweep_addr_d = '0;
              sweep_last_d = AW'(Depth - 1);
              state_d      = ST_SWEEP;
            end
            tccw_pkg::CMD_READ: begin
              if (read_in_range) begin
                state_d = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cell_d  = ram_rdata_i;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      col_q        <= '0;
      row_q        <= '0;
      top_q        <= '0;
      sweep_addr_q <= '0;
      sweep_last_q <= AW'(Depth - 1);
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      top_q        <= top_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scrolled_q <= scrolled_d;
    cell_q     <= cell_d;
  end

endmodule

[rtl/core/tccw_out_reg.sv]
// ----------------------------------------------------------------------------
// Text console output register
// Holds one result so the sequencer can move on while the receiver stalls.
// ----------------------------------------------------------------------------
module tccw_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  tccw_pkg::result_t res_i,
  output logic              res_ready_o,
  output logic              out_valid_o,
  output tccw_pkg::result_t out_o,
  input  logic              out_ready_i
);

  logic              valid_q, valid_d;
  tccw_pkg::result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

[rtl/core/text_console_cell_writer_unit.sv]
// ----------------------------------------------------------------------------
// Text console cell writer
// Teletype-style console over a COLUMNS x ROWS character cell memory.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel (command in tuser, character and
// read position in tdata); every transaction yields exactly one result on
// the m_axis channel with the cursor after the command, a scroll flag and
// the cell read by a read command.
// Items are handled one at a time, all work passing through the single
// write port of the cell memory. A plain put, newline, backspace or unused
// command is finished on acceptance; a read passes through a read state for
// the registered cell data. A scroll rotates the row offset and blanks the
// old top row, now the bottom row; a clear blanks ROWS*COLUMNS cells, one
// a cycle. Both blanks run through a sweep state. The next transaction is
// taken once the previous result has moved into the output register, so a
// stalled receiver blocks input only when a second result is also finished.
// After reset, which homes the cursor, the block sweeps zeros through all
// ROWS*COLUMNS cells (2000 by default) with s_axis_tready_o low.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_unit_assert.svh"

module text_console_cell_writer_unit #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero[23:20]
  input  logic [tccw_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [tccw_pkg::CMD_W-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // cursor_col[6:0], cursor_row[11:7], scrolled[12], cell_char[20:13], zero[23:21]
  output logic [tccw_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int AddrW = $clog2(ROWS * COLUMNS);

  logic                        seq_res_valid;
  logic                        seq_res_ready;
  tccw_pkg::result_t           seq_res;
  tccw_pkg::result_t           out_res;
  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [tccw_pkg::CHAR_W-1:0] ram_wdata;
  logic [AddrW-1:0]            ram_raddr;
  logic [tccw_pkg::CHAR_W-1:0] ram_rdata;
  logic                        in_accept;
  logic                        scroll_home;

  tccw_cell_ram #(
    .DEPTH (ROWS * COLUMNS),
    .AW    (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tccw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .char_code_i (s_axis_tdata_i[7:0]),
    .read_row_i  (s_axis_tdata_i[12:8]),
    .read_col_i  (s_axis_tdata_i[19:13]),
    .res_valid_o (seq_res_valid),
    .res_o       (seq_res),
    .res_ready_i (seq_res_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tccw_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (seq_res_valid),
    .res_i       (seq_res),
    .res_ready_o (seq_res_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {3'b000, out_res};

  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign scroll_home = (seq_res.cursor_row == 5'(ROWS - 1)) && (seq_res.cursor_col == '0);

  // Only one command is in flight at a time.
  `TCCW_ASSERT_IMPLIES(a_one_in_flight, clk_i, rst_ni, seq_res_valid, !s_axis_tready_o)
  `TCCW_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, !s_axis_tready_o)
  // A scroll always leaves the cursor at the start of the bottom row.
  `TCCW_ASSERT_IMPLIES(a_scroll_home, clk_i, rst_ni, seq_res_valid && seq_res.scrolled, scroll_home)

endmodule

[sim/text_console_cell_writer_unit_tb.sv]
// ----------------------------------------------------------------------------
// Text console cell writer testbench
// Drives console commands with random gaps and receiver stalls, predicts
// every result with a behavioral screen model and checks each result field.
// ----------------------------------------------------------------------------

class console_scoreboard;

  localparam int COLS = tccw_pkg::COLUMNS_DEF;
  localparam int ROWS = tccw_pkg::ROWS_DEF;

  bit [7:0] screen [ROWS][COLS];
  int unsigned cur_col;
  int unsigned cur_row;
  tccw_pkg::result_t results_due [$];
  int unsigned errors;
  int unsigned results_seen;

  task report(string msg);
    errors++;
    if (errors <= 100) begin
      $display("MISMATCH @%0t result #%0d: %s", $time, results_seen, msg);
    end
  endtask

  // Cursor to column 0 of the next row; scrolls when it leaves the bottom row.
  function bit line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) begin
      return 1'b0;
    end
    for (int r = 0; r + 1 < ROWS; r++) begin
      screen[r] = screen[r + 1];
    end
    for (int c = 0; c < COLS; c++) begin
      screen[ROWS - 1][c] = 8'd0;
    end
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function void note_command(logic [1:0] cmd, logic [7:0] ch, logic [4:0] rd_row,
                             logic [6:0] rd_col);
    tccw_pkg::result_t res;
    res = '0;
    case (cmd)
      tccw_pkg::CMD_PUT: begin
        if (ch == tccw_pkg::CHAR_NEWLINE) begin
          res.scrolled = line_feed();
        end else if (ch == tccw_pkg::CHAR_BACKSPACE) begin
          // Backspace at the left margin leaves everything as it is.
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_row][cur_col] = 8'd0;
          end
        end else begin
          screen[cur_row][cur_col] = ch;
          cur_col++;
          if (cur_col >= COLS) begin
            res.scrolled = line_feed();
          end
        end
      end
      tccw_pkg::CMD_CLEAR: begin
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLS; c++) begin
            screen[r][c] = 8'd0;
          end
        end
        cur_col = 0;
        cur_row = 0;
      end
      tccw_pkg::CMD_READ: begin
        if (rd_row < ROWS && rd_col < COLS) begin
          res.cell_char = screen[rd_row][rd_col];
        end
      end
      default: begin
      end
    endcase
    res.cursor_col = cur_col[6:0];
    res.cursor_row = cur_row[4:0];
    results_due.push_back(res);
  endfunction

  task check_result(logic [tccw_pkg::M_TDATA_W-1:0] data);
    tccw_pkg::result_t got;
    tccw_pkg::result_t want;
    got = data[$bits(tccw_pkg::result_t)-1:0];
    results_seen++;
    if (results_due.size() == 0) begin
      report("result arrived with no command outstanding");
      return;
    end
    want = results_due.pop_front();
    if (got.cursor_col !== want.cursor_col) begin
      report($sformatf("cursor_col %0d, expected %0d", got.cursor_col, want.cursor_col));
    end
    if (got.cursor_row !== want.cursor_row) begin
      report($sformatf("cursor_row %0d, expected %0d", got.cursor_row, want.cursor_row));
    end
    if (got.scrolled !== want.scrolled) begin
      report($sformatf("scrolled %0b, expected %0b", got.scrolled, want.scrolled));
    end
    if (got.cell_char !== want.cell_char) begin
      report($sformatf("cell_char %0d, expected %0d", got.cell_char, want.cell_char));
    end
  endtask

  function int pending();
    return results_due.size();
  endfunction

endclass

module text_console_cell_writer_unit_tb;

  localparam logic [tccw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CHUNKS = 19;
  localparam int CHUNK_ITEMS = 100;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [tccw_pkg::S_TDATA_W-1:0] s_axis_tdata_i;
  logic [tccw_pkg::CMD_W-1:0]     s_axis_tuser_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [tccw_pkg::M_TDATA_W-1:0] m_axis_tdata_o;

  console_scoreboard sb = new();

  bit src_idle_on;
  bit snk_idle_on;
  bit hold_request;

  text_console_cell_writer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one command and returns in the time step of its transaction.
  task automatic send_command(logic [1:0] cmd, logic [7:0] ch, logic [4:0] rd_row,
                              logic [6:0] rd_col);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'd0, rd_col, rd_row, ch};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(cmd, ch, rd_row, rd_col);
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic put_char(logic [7:0] ch);
    send_command(tccw_pkg::CMD_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(logic [4:0] rd_row, logic [6:0] rd_col);
    send_command(tccw_pkg::CMD_READ, 8'($urandom_range(0, 255)), rd_row, rd_col);
  endtask

  // Mostly text with line breaks; reads, clears and the unused command mixed in.
  task automatic run_chunk(int count, int newline_pct);
    int pick;
    int kind;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 999);
      if (pick < 5) begin
        send_command(tccw_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
      end else if (pick < 25) begin
        send_command(CMD_UNUSED, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
      end else if (pick < 250) begin
        if ($urandom_range(0, 9) == 0) begin
          read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        end else begin
          read_cell(5'($urandom_range(0, tccw_pkg::ROWS_DEF - 1)),
                    7'($urandom_range(0, tccw_pkg::COLUMNS_DEF - 1)));
        end
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < newline_pct) begin
          put_char(tccw_pkg::CHAR_NEWLINE);
        end else if (kind < newline_pct + 8) begin
          put_char(tccw_pkg::CHAR_BACKSPACE);
        end else begin
          put_char(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    int newline_pct;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    hold_request    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corner cases.
    read_cell(5'd0, 7'd0);
    read_cell(5'd24, 7'd79);
    put_char(tccw_pkg::CHAR_BACKSPACE);
    put_char(8'd0);
    put_char(8'd255);
    put_char(8'd65);
    put_char(tccw_pkg::CHAR_BACKSPACE);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd2);
    put_char(tccw_pkg::CHAR_NEWLINE);
    put_char(8'd127);
    read_cell(5'd31, 7'd0);
    read_cell(5'd0, 7'd127);
    read_cell(5'd25, 7'd80);
    send_command(CMD_UNUSED, 8'd255, 5'd31, 7'd127);
    read_cell(5'd1, 7'd0);
    send_command(tccw_pkg::CMD_CLEAR, 8'd0, 5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd1, 7'd0);
    put_char(8'd170);
    put_char(8'd85);
    read_cell(5'd0, 7'd0);
    s_axis_tvalid_i <= 1'b0;
    wait_results();

    for (int k = 0; k < CHUNKS; k++) begin
      case (k % 3)
        0: newline_pct = 2;
        1: newline_pct = 12;
        default: newline_pct = 30;
      endcase
      src_idle_on = (k < CHUNKS - 3) && ($urandom_range(0, 3) != 0);
      snk_idle_on = (k < CHUNKS - 3) && ($urandom_range(0, 3) != 0);
      if (k == 4) begin
        // Receiver holds off while commands keep coming, so the input backs up.
        src_idle_on  = 1'b0;
        hold_request = 1'b1;
      end
      if (k == 9) begin
        s_axis_tvalid_i <= 1'b0;
        wait_results();
      end
      run_chunk(CHUNK_ITEMS, newline_pct);
    end
    s_axis_tvalid_i <= 1'b0;

    wait_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: checks each transaction and paces tready.
  initial begin
    int stall_left;
    stall_left      = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tdata_o);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (snk_idle_on && rst_ni && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
